// File: sv/lps_pkg.sv
// Shared constants for the lexicographic permutation stepper.
// No dependencies; lps_if, lps_ctrl and the top level refer to names here by scope.
`timescale 1ns / 1ps

package lps_pkg;

   // Fixed field widths of the request and response channels
   localparam int ELEMENT_W  = 8;
   localparam int POSITION_W = 4;

   // Request mode codes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_STEP = 1'b1;

   // Direction register codes
   localparam logic DIR_NEXT = 1'b0;
   localparam logic DIR_PREV = 1'b1;

   // Register select bit (word index taken from paddr[2])
   localparam logic CSR_DIRECTION = 1'b0;

endpackage

// File: sv/lps_if.sv
// Valid/ready channel interfaces for request and response transfers.
// Depends on lps_pkg for the field widths.
`timescale 1ns / 1ps

interface lps_req_if;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [lps_pkg::ELEMENT_W-1:0] value;
   logic                          first;

   modport source (output valid, output mode, output value, output first, input ready);
   modport sink   (input valid, input mode, input value, input first, output ready);
endinterface

interface lps_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lps_pkg::ELEMENT_W-1:0]  element;
   logic [lps_pkg::POSITION_W-1:0] position;
   logic                           last;
   logic                           found;
   logic                           truncated;

   modport source (output valid, output element, output position, output last,
                   output found, output truncated, input ready);
   modport sink   (input valid, input element, input position, input last,
                   input found, input truncated, output ready);
endinterface

// File: sv/lps_store.sv
// Sequence memory: one write port, one read port, registered read data.
// Standalone; used by lps_ctrl.
`timescale 1ns / 1ps

module lps_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/lps_ctrl.sv
// Sequencer for loads, pivot search, swap/reverse and emission.
// Depends on lps_pkg, lps_if and lps_store.
`timescale 1ns / 1ps

module lps_ctrl #(
   parameter int MAX_LEN    = 16,
   parameter int ELEM_WIDTH = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         direction,
   lps_req_if.sink      req_ch,
   lps_rsp_if.source    rsp_ch
);

   localparam int IW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_PS_START = 12'b0000_0000_0010,
      ST_PS_FIRST = 12'b0000_0000_0100,
      ST_PS_SCAN  = 12'b0000_0000_1000,
      ST_KS_START = 12'b0000_0001_0000,
      ST_KS_SCAN  = 12'b0000_0010_0000,
      ST_X_RD_LO  = 12'b0000_0100_0000,
      ST_X_RD_HI  = 12'b0000_1000_0000,
      ST_X_WR_LO  = 12'b0001_0000_0000,
      ST_X_WR_HI  = 12'b0010_0000_0000,
      ST_EMIT_RD  = 12'b0100_0000_0000,
      ST_EMIT     = 12'b1000_0000_0000
   } state_type;

   // true when a goes before b in the active direction
   function automatic logic ordered_before(input logic [ELEM_WIDTH-1:0] a,
                                           input logic [ELEM_WIDTH-1:0] b,
                                           input logic                  dir);
      logic res;
      if (dir == lps_pkg::DIR_PREV) begin
         res = (a > b);
      end else begin
         res = (a < b);
      end
      return res;
   endfunction

   state_type              state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   ovf_ff, ovf_in;
   logic                   found_ff, found_in;
   logic [IW-1:0]          ptr_ff, ptr_in;
   logic [IW-1:0]          piv_ff, piv_in;
   logic [IW-1:0]          lo_ff, lo_in;
   logic [IW-1:0]          hi_ff, hi_in;
   logic                   rev_ff, rev_in;
   logic [ELEM_WIDTH-1:0]  pivval_ff, pivval_in;
   logic [ELEM_WIDTH-1:0]  right_ff, right_in;
   logic [ELEM_WIDTH-1:0]  hold_ff, hold_in;

   logic                             out_valid_ff, out_valid_in;
   logic [lps_pkg::ELEMENT_W-1:0]    out_elem_ff, out_elem_in;
   logic [lps_pkg::POSITION_W-1:0]   out_pos_ff, out_pos_in;
   logic                             out_last_ff, out_last_in;
   logic                             out_found_ff, out_found_in;
   logic                             out_trunc_ff, out_trunc_in;

   logic                  mem_we, mem_re;
   logic [IW-1:0]         mem_waddr, mem_raddr;
   logic [ELEM_WIDTH-1:0] mem_wdata, mem_rdata;

   logic [CW-1:0]         cnt_m1;
   logic [IW-1:0]         last_idx;
   logic [IW-1:0]         piv_p1;
   logic [31:0]           val_ext, rd_ext, ptr_ext;
   logic                  out_free;

   lps_store #(
      .DEPTH(MAX_LEN),
      .WIDTH(ELEM_WIDTH)
   ) u_store (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .re   (mem_re),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   assign cnt_m1   = cnt_ff - CW'(1);
   assign last_idx = cnt_m1[IW-1:0];
   assign piv_p1   = piv_ff + IW'(1);
   assign val_ext  = 32'(req_ch.value);
   assign rd_ext   = 32'(mem_rdata);
   assign ptr_ext  = 32'(ptr_ff);
   assign out_free = !out_valid_ff || rsp_ch.ready;

   assign req_ch.ready = (state_ff == ST_IDLE);

   // next-state and memory access sequencing
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      found_in     = found_ff;
      ptr_in       = ptr_ff;
      piv_in       = piv_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rev_in       = rev_ff;
      pivval_in    = pivval_ff;
      right_in     = right_ff;
      hold_in      = hold_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_elem_in  = out_elem_ff;
      out_pos_in   = out_pos_ff;
      out_last_in  = out_last_ff;
      out_found_in = out_found_ff;
      out_trunc_in = out_trunc_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = val_ext[ELEM_WIDTH-1:0];
      mem_re       = 1'b0;
      mem_raddr    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.mode == lps_pkg::MODE_LOAD) begin
                  if (req_ch.first) begin
                     mem_we    = 1'b1;
                     mem_waddr = '0;
                     cnt_in    = CW'(1);
                     ovf_in    = 1'b0;
                  end else if (cnt_ff < CW'(MAX_LEN)) begin
                     mem_we    = 1'b1;
                     mem_waddr = cnt_ff[IW-1:0];
                     cnt_in    = cnt_ff + CW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  found_in = 1'b0;
                  if (cnt_ff < CW'(2)) begin
                     state_in = ST_EMIT_RD;
                  end else begin
                     state_in = ST_PS_START;
                  end
               end
            end
         end
         // pivot scan from the right, one element per cycle
         ST_PS_START: begin
            mem_re    = 1'b1;
            mem_raddr = last_idx;
            ptr_in    = last_idx;
            state_in  = ST_PS_FIRST;
         end
         ST_PS_FIRST: begin
            right_in  = mem_rdata;
            mem_re    = 1'b1;
            mem_raddr = ptr_ff - IW'(1);
            ptr_in    = ptr_ff - IW'(1);
            state_in  = ST_PS_SCAN;
         end
         ST_PS_SCAN: begin
            if (ordered_before(mem_rdata, right_ff, direction)) begin
               piv_in    = ptr_ff;
               pivval_in = mem_rdata;
               found_in  = 1'b1;
               state_in  = ST_KS_START;
            end else if (ptr_ff == '0) begin
               state_in = ST_EMIT_RD;
            end else begin
               right_in  = mem_rdata;
               mem_re    = 1'b1;
               mem_raddr = ptr_ff - IW'(1);
               ptr_in    = ptr_ff - IW'(1);
            end
         end
         // rightmost element that the pivot goes before
         ST_KS_START: begin
            mem_re    = 1'b1;
            mem_raddr = last_idx;
            ptr_in    = last_idx;
            state_in  = ST_KS_SCAN;
         end
         ST_KS_SCAN: begin
            if (ordered_before(pivval_ff, mem_rdata, direction) || ptr_ff == piv_p1) begin
               lo_in    = piv_ff;
               hi_in    = ptr_ff;
               rev_in   = 1'b0;
               state_in = ST_X_RD_LO;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = ptr_ff - IW'(1);
               ptr_in    = ptr_ff - IW'(1);
            end
         end
         // pair exchange: pivot swap first, then tail reversal
         ST_X_RD_LO: begin
            mem_re    = 1'b1;
            mem_raddr = lo_ff;
            state_in  = ST_X_RD_HI;
         end
         ST_X_RD_HI: begin
            hold_in   = mem_rdata;
            mem_re    = 1'b1;
            mem_raddr = hi_ff;
            state_in  = ST_X_WR_LO;
         end
         ST_X_WR_LO: begin
            mem_we    = 1'b1;
            mem_waddr = lo_ff;
            mem_wdata = mem_rdata;
            state_in  = ST_X_WR_HI;
         end
         ST_X_WR_HI: begin
            mem_we    = 1'b1;
            mem_waddr = hi_ff;
            mem_wdata = hold_ff;
            if (!rev_ff) begin
               lo_in  = piv_p1;
               hi_in  = last_idx;
               rev_in = 1'b1;
            end else begin
               lo_in = lo_ff + IW'(1);
               hi_in = hi_ff - IW'(1);
            end
            if (lo_in < hi_in) begin
               state_in = ST_X_RD_LO;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         // emission, next read overlapped with each output load
         ST_EMIT_RD: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            ptr_in    = '0;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_elem_in  = (cnt_ff == '0) ? '0 : rd_ext[lps_pkg::ELEMENT_W-1:0];
               out_pos_in   = ptr_ext[lps_pkg::POSITION_W-1:0];
               out_last_in  = (cnt_ff == '0) || (ptr_ff == last_idx);
               out_found_in = found_ff;
               out_trunc_in = ovf_ff;
               if (out_last_in) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = ptr_ff + IW'(1);
                  ptr_in    = ptr_ff + IW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         found_ff     <= found_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      piv_ff       <= piv_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      rev_ff       <= rev_in;
      pivval_ff    <= pivval_in;
      right_ff     <= right_in;
      hold_ff      <= hold_in;
      out_elem_ff  <= out_elem_in;
      out_pos_ff   <= out_pos_in;
      out_last_ff  <= out_last_in;
      out_found_ff <= out_found_in;
      out_trunc_ff <= out_trunc_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.element   = out_elem_ff;
   assign rsp_ch.position  = out_pos_ff;
   assign rsp_ch.last      = out_last_ff;
   assign rsp_ch.found     = out_found_ff;
   assign rsp_ch.truncated = out_trunc_ff;

endmodule

// File: sv/lexicographic_permutation_step.sv
// Lexicographic permutation stepper. Load transfers (mode 0) write one element into the
// sequence memory (or, once it is full, drop it and flag truncation) and return nothing; a
// step transfer (mode 1) rewrites the held sequence into its next (direction 0) or previous
// (direction 1) permutation and then returns every element in order, one response per cycle
// when the sink keeps up. Everything goes through one single-port-read, single-port-write
// memory, so a step of n elements with pivot p is accepted, scans for the pivot from the
// right, searches for the swap partner, exchanges the pivot pair and then the (n - p - 1) / 2
// tail pairs, and then emits the sequence. Requests are taken only between steps; the last
// response may still wait in its output register while the next request is accepted.
// Depends on lps_pkg, lps_if, lps_store and lps_ctrl.
`timescale 1ns / 1ps

module lexicographic_permutation_step #(
   parameter int MAX_LEN    = 16,
   parameter int ELEM_WIDTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   lps_req_if.sink     req_ch,
   lps_rsp_if.source   rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic direction_ff, direction_in;
   logic csr_wr;

   // register write at the access phase
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      direction_in = direction_ff;
      if (csr_wr && paddr[2] == lps_pkg::CSR_DIRECTION) begin
         direction_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= lps_pkg::DIR_NEXT;
      end else begin
         direction_ff <= direction_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == lps_pkg::CSR_DIRECTION) ? {31'd0, direction_ff} : 32'd0;

   lps_ctrl #(
      .MAX_LEN   (MAX_LEN),
      .ELEM_WIDTH(ELEM_WIDTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .direction(direction_ff),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch)
   );

endmodule
